FILE: hw/rtl/hre_pkg.sv
// hre_pkg: shared types and constants of the homography reprojection error unit
// no dependencies
`timescale 1ns / 1ps

package hre_pkg;

  // start of one iterative unit and the number of steps it runs
  typedef struct packed {
    logic       start;
    logic [6:0] iters;
  } hre_ctl_t;

  // norm codes
  localparam logic [2:0] NORM_MAX = 3'd0;
  localparam logic [2:0] NORM_L1  = 3'd1;
  localparam logic [2:0] NORM_L2  = 3'd2;
  localparam logic [2:0] NORM_L3  = 3'd3;
  localparam logic [2:0] NORM_L4  = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_H00_01 = 3'd0;
  localparam logic [2:0] CFG_H02_10 = 3'd1;
  localparam logic [2:0] CFG_H11_12 = 3'd2;
  localparam logic [2:0] CFG_H20_21 = 3'd3;
  localparam logic [2:0] CFG_H22    = 3'd4;
  localparam logic [2:0] CFG_NORM   = 3'd5;

  localparam logic [31:0] H_ONE    = 32'h4000_0000;
  localparam logic [2:0]  NORM_RST = NORM_L2;

endpackage

FILE: hw/rtl/hre_mul.sv
// hre_mul: shared 33x33 signed multiplier with registered product
// no dependencies
`timescale 1ns / 1ps

module hre_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/hre_div.sv
// hre_div: restoring divider, one quotient bit per cycle
// depends on hre_pkg
`timescale 1ns / 1ps

module hre_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hre_pkg::hre_ctl_t ctl_i,
  input  logic [63:0]       rem_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  output logic              busy_o,
  output logic [63:0]       quo_o
);
  import hre_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [64:0] rs;
  logic [64:0] diff;
  logic        ge;

  assign rs   = {rem_q, num_q[63]};
  assign ge   = rs >= {1'b0, den_q};
  assign diff = rs - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (ctl_i.start) begin
      busy_d = (ctl_i.iters != 7'd0);
      cnt_d  = ctl_i.iters;
      rem_d  = rem_i;
      num_d  = num_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[63:0] : rs[63:0];
      quo_d  = {quo_q[62:0], ge};
      num_d  = {num_q[62:0], 1'b0};
      cnt_d  = cnt_q - 7'd1;
      busy_d = (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/hre_sqrt.sv
// hre_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on hre_pkg; radicand is left aligned in 96 bits
`timescale 1ns / 1ps

module hre_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hre_pkg::hre_ctl_t ctl_i,
  input  logic [95:0]       rad_i,
  output logic              busy_o,
  output logic [47:0]       root_o
);
  import hre_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [95:0] x_q, x_d;
  logic [49:0] rem_q, rem_d;
  logic [47:0] root_q, root_d;
  logic [51:0] rem_s;
  logic [51:0] trial;
  logic        ge;

  assign rem_s = {rem_q, x_q[95:94]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = rem_s >= trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctl_i.start) begin
      busy_d = (ctl_i.iters != 7'd0);
      cnt_d  = ctl_i.iters;
      x_d    = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? 50'(rem_s - trial) : rem_s[49:0];
      root_d = {root_q[46:0], ge};
      x_d    = {x_q[93:0], 2'b00};
      cnt_d  = cnt_q - 7'd1;
      busy_d = (cnt_q != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

FILE: hw/rtl/homography_reprojection_error_unit.sv
// homography_reprojection_error_unit: top level, sequencer and accumulator
// depends on hre_pkg, hre_mul, hre_div, hre_sqrt
`timescale 1ns / 1ps

// Maps each world point through the configured homography, takes the distance to
// the camera point and folds it into the selected norm; the beat marked last
// emits the error, divided by the point count for all norms but max. One item at
// a time: six projection multiplies, a projection divide of 48 quotient bits and
// a distance root of 32 bits. A last beat adds no root or divide for max, a count
// divide for L1, a root and the count divide for L2, 27 cube-root bits and the
// count divide for L3, or two roots and the count divide for L4. A finished
// result waits in the output register while the next item is taken.
module homography_reprojection_error_unit #(
  parameter int MAX_POINTS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic signed [31:0] cam_x_i,
  input  logic signed [31:0] cam_y_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] error_o,
  output logic        saturated_o,
  output logic [16:0] point_count_o
);
  import hre_pkg::*;

  localparam int CntW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PROJ = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIVW = 4'd3;
  localparam logic [3:0] S_DIST = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_TERM = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_RTW  = 4'd9;
  localparam logic [3:0] S_CUBE = 4'd10;
  localparam logic [3:0] S_DIVF = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  // configuration
  logic signed [31:0] h00_q, h01_q, h02_q, h10_q, h11_q, h12_q, h20_q, h21_q, h22_q;
  logic [2:0]         norm_q;
  logic [2:0]         nrm;

  // control state
  logic [3:0]      state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic [2:0]      u_q, u_d;
  logic [4:0]      bit_q, bit_d;
  logic            rstage_q, rstage_d;
  logic [63:0]     acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;

  // item payload and working registers
  logic signed [31:0] wx_q, wx_d, wy_q, wy_d, cx_q, cx_d, cy_q, cy_d;
  logic               last_q, last_d;
  logic signed [63:0] nx_q, nx_d, ny_q, ny_d, dz_q, dz_d;
  logic               sx_q, sx_d, sy_q, sy_d;
  logic [31:0]        ax_q, ax_d, ay_q, ay_d;
  logic [64:0]        sum_q, sum_d;
  logic [31:0]        d_q, d_d;
  logic [63:0]        d2_q, d2_d;
  logic [127:0]       prod_q, prod_d;
  logic [53:0]        c2_q, c2_d;
  logic [26:0]        r_q, r_d;
  logic [63:0]        err_q, err_d;
  logic [31:0]        oerr_q, oerr_d;
  logic               osat_q, osat_d;
  logic [16:0]        ocnt_q, ocnt_d;

  // shared units
  logic signed [32:0] ma, mb;
  logic signed [65:0] p;
  logic signed [63:0] pq;
  hre_ctl_t           div0_ctl, div1_ctl, sqrt_ctl;
  logic [63:0]        div0_rem, div0_num, div0_den, div1_rem, div1_num, div1_den;
  logic [63:0]        quo0, quo1;
  logic               div0_busy, div1_busy, sqrt_busy;
  logic [95:0]        sqrt_rad;
  logic [47:0]        root;

  // combinational helpers
  logic [63:0]        nmx, nmy, dmag, nden;
  logic signed [49:0] px, py, dxs, dys;
  logic [49:0]        ax50, ay50;
  logic [26:0]        cc;
  logic [79:0]        cube_x;
  logic [2:0]         jj;
  logic [2:0]         nops;
  logic [63:0]        term;
  logic               tovf;
  logic [64:0]        asum;
  logic [63:0]        pl;
  logic               sat;
  logic [CntW+16:0]   cnt_ext;

  assign nrm     = (norm_q > NORM_L4) ? NORM_MAX : norm_q;
  assign pq      = p[65:2];
  assign pl      = p[63:0];
  assign nmx     = nx_q[63] ? 64'(-nx_q) : 64'(nx_q);
  assign nmy     = ny_q[63] ? 64'(-ny_q) : 64'(ny_q);
  assign dmag    = dz_q[63] ? 64'(-dz_q) : 64'(dz_q);
  assign nden    = (cnt_q == '0) ? 64'd1 : 64'(cnt_q);
  assign px      = sx_q ? -$signed({2'b00, quo0[47:0]}) : $signed({2'b00, quo0[47:0]});
  assign py      = sy_q ? -$signed({2'b00, quo1[47:0]}) : $signed({2'b00, quo1[47:0]});
  assign dxs     = $signed({{18{cx_q[31]}}, cx_q}) - px;
  assign dys     = $signed({{18{cy_q[31]}}, cy_q}) - py;
  assign ax50    = dxs[49] ? 50'(-dxs) : 50'(dxs);
  assign ay50    = dys[49] ? 50'(-dys) : 50'(dys);
  assign cc      = r_q | (27'd1 << bit_q);
  assign cube_x  = {acc_q, 16'd0};
  assign jj      = step_q - 3'd2;
  assign nops    = (nrm == NORM_L3) ? 3'd2 : 3'd4;
  assign asum    = {1'b0, acc_q} + {1'b0, term};
  assign sat     = ovf_q || (err_q[63:32] != 32'd0);
  assign cnt_ext = {17'd0, cnt_q};

  always_comb begin
    term = d2_q;
    tovf = 1'b0;
    case (nrm)
      NORM_L1: term = {16'd0, d_q, 16'd0};
      NORM_L2: term = d2_q;
      NORM_L3: begin
        term = prod_q[79:16];
        tovf = (prod_q[127:80] != 48'd0);
      end
      NORM_L4: begin
        term = prod_q[95:32];
        tovf = (prod_q[127:96] != 32'd0);
      end
      default: term = d2_q;
    endcase
  end

  hre_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (p)
  );

  hre_div u_div0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div0_ctl),
    .rem_i  (div0_rem),
    .num_i  (div0_num),
    .den_i  (div0_den),
    .busy_o (div0_busy),
    .quo_o  (quo0)
  );

  hre_div u_div1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div1_ctl),
    .rem_i  (div1_rem),
    .num_i  (div1_num),
    .den_i  (div1_den),
    .busy_o (div1_busy),
    .quo_o  (quo1)
  );

  hre_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sqrt_ctl),
    .rad_i  (sqrt_rad),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    u_d         = u_q;
    bit_d       = bit_q;
    rstage_d    = rstage_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    wx_d = wx_q;  wy_d = wy_q;  cx_d = cx_q;  cy_d = cy_q;
    last_d = last_q;
    nx_d = nx_q;  ny_d = ny_q;  dz_d = dz_q;
    sx_d = sx_q;  sy_d = sy_q;
    ax_d = ax_q;  ay_d = ay_q;
    sum_d  = sum_q;
    d_d    = d_q;
    d2_d   = d2_q;
    prod_d = prod_q;
    c2_d   = c2_q;
    r_d    = r_q;
    err_d  = err_q;
    oerr_d = oerr_q;
    osat_d = osat_q;
    ocnt_d = ocnt_q;
    ma = '0;
    mb = '0;
    div0_ctl = '0;  div1_ctl = '0;  sqrt_ctl = '0;
    div0_rem = '0;  div0_num = '0;  div0_den = 64'd1;
    div1_rem = '0;  div1_num = '0;  div1_den = 64'd1;
    sqrt_rad = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wx_d   = world_x_i;
          wy_d   = world_y_i;
          cx_d   = cam_x_i;
          cy_d   = cam_y_i;
          last_d = last_i;
          nx_d   = {{20{h02_q[31]}}, h02_q, 12'd0};
          ny_d   = {{20{h12_q[31]}}, h12_q, 12'd0};
          dz_d   = {{20{h22_q[31]}}, h22_q, 12'd0};
          if (cnt_q < CntW'(MAX_POINTS)) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          step_d  = '0;
          state_d = S_PROJ;
        end
      end

      S_PROJ: begin
        case (step_q)
          3'd0: begin ma = {wx_q[31], wx_q}; mb = {h00_q[31], h00_q}; end
          3'd1: begin ma = {wy_q[31], wy_q}; mb = {h01_q[31], h01_q}; end
          3'd2: begin ma = {wx_q[31], wx_q}; mb = {h10_q[31], h10_q}; end
          3'd3: begin ma = {wy_q[31], wy_q}; mb = {h11_q[31], h11_q}; end
          3'd4: begin ma = {wx_q[31], wx_q}; mb = {h20_q[31], h20_q}; end
          3'd5: begin ma = {wy_q[31], wy_q}; mb = {h21_q[31], h21_q}; end
          default: begin ma = '0; mb = '0; end
        endcase
        case (step_q)
          3'd1, 3'd2: nx_d = nx_q + pq;
          3'd3, 3'd4: ny_d = ny_q + pq;
          3'd5, 3'd6: dz_d = dz_q + pq;
          default: nx_d = nx_q;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        if ((dz_q == 64'sd0) || ({32'd0, nmx[63:32]} >= dmag)
            || ({32'd0, nmy[63:32]} >= dmag)) begin
          ovf_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          div0_ctl = '{start: 1'b1, iters: 7'd48};
          div0_rem = {32'd0, nmx[63:32]};
          div0_num = {nmx[31:0], 32'd0};
          div0_den = dmag;
          div1_ctl = '{start: 1'b1, iters: 7'd48};
          div1_rem = {32'd0, nmy[63:32]};
          div1_num = {nmy[31:0], 32'd0};
          div1_den = dmag;
          sx_d     = nx_q[63] ^ dz_q[63];
          sy_d     = ny_q[63] ^ dz_q[63];
          state_d  = S_DIVW;
        end
      end

      S_DIVW: begin
        if (!div0_busy && !div1_busy) begin
          if ((ax50[49:32] != 18'd0) || (ay50[49:32] != 18'd0)) begin
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            ax_d    = ax50[31:0];
            ay_d    = ay50[31:0];
            step_d  = '0;
            state_d = S_DIST;
          end
        end
      end

      S_DIST: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin ma = {1'b0, ax_q}; mb = {1'b0, ax_q}; end
          3'd1: begin
            ma    = {1'b0, ay_q};
            mb    = {1'b0, ay_q};
            sum_d = {1'b0, pl};
          end
          3'd2: sum_d = sum_q + {1'b0, pl};
          default: begin
            if (sum_q[64]) begin
              ovf_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              sqrt_ctl = '{start: 1'b1, iters: 7'd32};
              sqrt_rad = {sum_q[63:0], 32'd0};
              state_d  = S_SQW;
            end
          end
        endcase
      end

      S_SQW: begin
        if (!sqrt_busy) begin
          d_d     = root[31:0];
          step_d  = '0;
          state_d = S_TERM;
        end
      end

      S_TERM: begin
        step_d = step_q + 3'd1;
        if (nrm == NORM_MAX) begin
          if ({32'd0, d_q} > acc_q) begin
            acc_d = {32'd0, d_q};
          end
          state_d = S_DONE;
        end else if (nrm == NORM_L1) begin
          state_d = S_ACC;
        end else if (step_q == 3'd0) begin
          ma = {1'b0, d_q};
          mb = {1'b0, d_q};
        end else if (step_q == 3'd1) begin
          d2_d   = pl;
          prod_d = '0;
          if (nrm == NORM_L2) begin
            state_d = S_ACC;
          end
        end else begin
          if (jj < nops) begin
            if (nrm == NORM_L3) begin
              ma = (jj == 3'd0) ? {1'b0, d2_q[31:0]} : {1'b0, d2_q[63:32]};
              mb = {1'b0, d_q};
            end else begin
              ma = (jj[1] == 1'b0) ? {1'b0, d2_q[31:0]} : {1'b0, d2_q[63:32]};
              mb = (jj[0] == 1'b0) ? {1'b0, d2_q[31:0]} : {1'b0, d2_q[63:32]};
            end
          end
          if (jj != 3'd0) begin
            if ((nrm == NORM_L4) && (jj == 3'd4)) begin
              prod_d = prod_q + {pl, 64'd0};
            end else if (jj == 3'd1) begin
              prod_d = prod_q + {64'd0, pl};
            end else begin
              prod_d = prod_q + {32'd0, pl, 32'd0};
            end
          end
          if (jj == nops) begin
            state_d = S_ACC;
          end
        end
      end

      S_ACC: begin
        if (tovf || asum[64]) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = asum[63:0];
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        rstage_d = 1'b0;
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          case (nrm)
            NORM_L1: begin
              div0_ctl = '{start: 1'b1, iters: 7'd64};
              div0_num = acc_q;
              div0_den = nden;
              state_d  = S_DIVF;
            end
            NORM_L2: begin
              sqrt_ctl = '{start: 1'b1, iters: 7'd32};
              sqrt_rad = {acc_q, 32'd0};
              state_d  = S_RTW;
            end
            NORM_L3: begin
              r_d     = '0;
              bit_d   = 5'd26;
              u_d     = '0;
              state_d = S_CUBE;
            end
            NORM_L4: begin
              sqrt_ctl = '{start: 1'b1, iters: 7'd48};
              sqrt_rad = {acc_q, 32'd0};
              state_d  = S_RTW;
            end
            default: begin
              err_d   = acc_q;
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_RTW: begin
        if (!sqrt_busy) begin
          if ((nrm == NORM_L4) && !rstage_q) begin
            rstage_d = 1'b1;
            sqrt_ctl = '{start: 1'b1, iters: 7'd24};
            sqrt_rad = {root, 48'd0};
          end else begin
            div0_ctl = '{start: 1'b1, iters: 7'd64};
            div0_num = {32'd0, root[31:0]};
            div0_den = nden;
            state_d  = S_DIVF;
          end
        end
      end

      S_CUBE: begin
        u_d = u_q + 3'd1;
        case (u_q)
          3'd0: begin ma = {6'd0, cc}; mb = {6'd0, cc}; end
          3'd1: c2_d = pl[53:0];
          3'd2: begin ma = {1'b0, c2_q[31:0]}; mb = {6'd0, cc}; end
          3'd3: begin
            ma     = {11'd0, c2_q[53:32]};
            mb     = {6'd0, cc};
            prod_d = {64'd0, pl};
          end
          3'd4: prod_d = prod_q + {32'd0, pl, 32'd0};
          default: begin
            u_d = '0;
            if (prod_q <= {48'd0, cube_x}) begin
              r_d = cc;
            end
            if (bit_q == 5'd0) begin
              div0_ctl = '{start: 1'b1, iters: 7'd64};
              div0_num = {37'd0, (prod_q <= {48'd0, cube_x}) ? cc : r_q};
              div0_den = nden;
              state_d  = S_DIVF;
            end else begin
              bit_d = bit_q - 5'd1;
            end
          end
        endcase
      end

      S_DIVF: begin
        if (!div0_busy) begin
          err_d   = (nrm == NORM_L1) ? {16'd0, quo0[63:16]} : quo0;
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          oerr_d      = sat ? 32'hFFFF_FFFF : err_q[31:0];
          osat_d      = sat;
          ocnt_d      = cnt_ext[16:0];
          acc_d       = '0;
          cnt_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h00_q  <= H_ONE;
      h01_q  <= '0;
      h02_q  <= '0;
      h10_q  <= '0;
      h11_q  <= H_ONE;
      h12_q  <= '0;
      h20_q  <= '0;
      h21_q  <= '0;
      h22_q  <= H_ONE;
      norm_q <= NORM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_H00_01: begin h00_q <= cfg_data_i[31:0]; h01_q <= cfg_data_i[63:32]; end
        CFG_H02_10: begin h02_q <= cfg_data_i[31:0]; h10_q <= cfg_data_i[63:32]; end
        CFG_H11_12: begin h11_q <= cfg_data_i[31:0]; h12_q <= cfg_data_i[63:32]; end
        CFG_H20_21: begin h20_q <= cfg_data_i[31:0]; h21_q <= cfg_data_i[63:32]; end
        CFG_H22:    h22_q  <= cfg_data_i[31:0];
        CFG_NORM:   norm_q <= cfg_data_i[2:0];
        default:    norm_q <= norm_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      u_q         <= '0;
      bit_q       <= '0;
      rstage_q    <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      u_q         <= u_d;
      bit_q       <= bit_d;
      rstage_q    <= rstage_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q   <= wx_d;
    wy_q   <= wy_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    last_q <= last_d;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    dz_q   <= dz_d;
    sx_q   <= sx_d;
    sy_q   <= sy_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    sum_q  <= sum_d;
    d_q    <= d_d;
    d2_q   <= d2_d;
    prod_q <= prod_d;
    c2_q   <= c2_d;
    r_q    <= r_d;
    err_q  <= err_d;
    oerr_q <= oerr_d;
    osat_q <= osat_d;
    ocnt_q <= ocnt_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign error_o       = oerr_q;
  assign saturated_o   = osat_q;
  assign point_count_o = ocnt_q;

endmodule

FILE: tb/sv/homography_reprojection_error_unit_tb.sv
// homography_reprojection_error_unit_tb: self-checking bench with a directed table and random sets
// depends on hre_pkg and homography_reprojection_error_unit
`timescale 1ns / 1ps

module homography_reprojection_error_unit_tb;
  import hre_pkg::*;

  localparam int MAX_PTS = 64;
  localparam int SETTLE = 400;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] cx;
    logic [31:0] cy;
    logic        last;
  } corr_t;

  typedef struct packed {
    logic [31:0] err;
    logic        sat;
    logic [16:0] cnt;
  } err_result_t;

  typedef struct packed {
    corr_t       it;
    logic        known;
    err_result_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic signed [31:0] world_x_i;
  logic signed [31:0] world_y_i;
  logic signed [31:0] cam_x_i;
  logic signed [31:0] cam_y_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] error_o;
  logic        saturated_o;
  logic [16:0] point_count_o;

  homography_reprojection_error_unit #(
    .MAX_POINTS(MAX_PTS)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .world_x_i(world_x_i),
    .world_y_i(world_y_i),
    .cam_x_i(cam_x_i),
    .cam_y_i(cam_y_i),
    .last_i(last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .error_o(error_o),
    .saturated_o(saturated_o),
    .point_count_o(point_count_o)
  );

  // predictor state
  logic [63:0] h_r [0:3];
  logic [31:0] h22_r;
  logic [2:0]  norm_r;
  logic [63:0] acc;
  int          pts;
  bit          ovf_seen;

  err_result_t pending_q [$];
  int          errors = 0;
  bit          idle_en = 1'b1;
  int          n_items = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint sx(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [31:0] int_root(logic [127:0] t, int p);
    logic [31:0]  r;
    logic [63:0]  c;
    logic [127:0] pw;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = {32'd0, r | (32'd1 << b)};
      pw = 128'(c) * c;
      if (p >= 3) pw = pw * c;
      if (p == 4) pw = pw * c;
      if (pw <= t) r = c[31:0];
    end
    return r;
  endfunction

  function automatic bit project_q16(longint num, longint den, output longint q);
    logic [127:0] n, d, qq;
    n = 128'(abs64(num));
    d = 128'(abs64(den));
    q = 0;
    if (n / d >= 128'h1_0000_0000) return 1'b0;
    qq = (n << 16) / d;
    q = ((num < 0) != (den < 0)) ? -longint'(qq[63:0]) : longint'(qq[63:0]);
    return 1'b1;
  endfunction

  function automatic bit point_dist(corr_t it, output logic [31:0] d);
    longint nx, ny, dz, px, py;
    logic [63:0]  ax, ay;
    logic [127:0] s;
    d = '0;
    nx = ((sx(it.wx) * sx(h_r[0][31:0])) >>> 2) + ((sx(it.wy) * sx(h_r[0][63:32])) >>> 2)
         + sx(h_r[1][31:0]) * 4096;
    ny = ((sx(it.wx) * sx(h_r[1][63:32])) >>> 2) + ((sx(it.wy) * sx(h_r[2][31:0])) >>> 2)
         + sx(h_r[2][63:32]) * 4096;
    dz = ((sx(it.wx) * sx(h_r[3][31:0])) >>> 2) + ((sx(it.wy) * sx(h_r[3][63:32])) >>> 2)
         + sx(h22_r) * 4096;
    if (dz == 0) return 1'b0;
    if (!project_q16(nx, dz, px) || !project_q16(ny, dz, py)) return 1'b0;
    ax = abs64(sx(it.cx) - px);
    ay = abs64(sx(it.cy) - py);
    if (ax[63:32] != 0 || ay[63:32] != 0) return 1'b0;
    s = 128'(ax) * ax + 128'(ay) * ay;
    if (s[127:64] != 0) return 1'b0;
    d = int_root(s, 2);
    return 1'b1;
  endfunction

  // folds one correspondence into the set; returns 1 when the set closes
  function automatic bit fold_point(corr_t it, output err_result_t r);
    logic [2:0]   nm;
    logic [31:0]  d;
    logic [127:0] term;
    logic [64:0]  sum;
    logic [63:0]  e, n;
    r = '0;
    nm = (norm_r > NORM_L4) ? NORM_MAX : norm_r;
    if (pts < MAX_PTS) pts++;
    else ovf_seen = 1'b1;
    if (!point_dist(it, d)) begin
      ovf_seen = 1'b1;
    end else if (nm == NORM_MAX) begin
      if (64'(d) > acc) acc = 64'(d);
    end else begin
      case (nm)
        NORM_L1: term = 128'(d) << 16;
        NORM_L2: term = 128'(d) * d;
        NORM_L3: term = (128'(d) * d * d) >> 16;
        default: term = (128'(d) * d * d * d) >> 32;
      endcase
      sum = 65'(acc) + 65'(term[63:0]);
      if (term[127:64] != 0 || sum[64]) ovf_seen = 1'b1;
      else acc = sum[63:0];
    end
    if (!it.last) return 1'b0;
    n = (pts != 0) ? 64'(pts) : 64'd1;
    case (nm)
      NORM_MAX: e = acc;
      NORM_L1:  e = (acc / n) >> 16;
      NORM_L2:  e = 64'(int_root(128'(acc), 2)) / n;
      NORM_L3:  e = 64'(int_root(128'(acc) << 16, 3)) / n;
      default:  e = 64'(int_root(128'(acc) << 32, 4)) / n;
    endcase
    r.sat = ovf_seen || (e[63:32] != 0);
    r.err = r.sat ? 32'hFFFF_FFFF : e[31:0];
    r.cnt = 17'(pts);
    acc = '0;
    pts = 0;
    ovf_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    err_result_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report("unexpected beat", error_o, 32'd0);
      end else begin
        w = pending_q.pop_front();
        if (error_o !== w.err) report("error", error_o, w.err);
        if (saturated_o !== w.sat) report("saturated", 32'(saturated_o), 32'(w.sat));
        if (point_count_o !== w.cnt) report("point_count", 32'(point_count_o), 32'(w.cnt));
      end
    end
  end

  // result side stall
  initial begin
    int k;
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      k = idle_en ? $urandom_range(0, 7) : 0;
      if (k > 0) begin
        out_stall_i <= 1'b1;
        repeat (k) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  task automatic send_item(corr_t it, logic known, err_result_t want);
    int gap;
    err_result_t r;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    world_x_i <= it.wx;
    world_y_i <= it.wy;
    cam_x_i <= it.cx;
    cam_y_i <= it.cy;
    last_i <= it.last;
    do @(posedge clk_i); while (in_stall_o);
    if (fold_point(it, r)) pending_q.push_back(known ? want : r);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_H00_01: h_r[0] = val;
      CFG_H02_10: h_r[1] = val;
      CFG_H11_12: h_r[2] = val;
      CFG_H20_21: h_r[3] = val;
      CFG_H22:    h22_r = val[31:0];
      CFG_NORM:   norm_r = val[2:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // drain: no item in flight and every result seen
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic load_h(logic [31:0] c [0:8]);
    cfg_write(CFG_H00_01, {c[1], c[0]});
    cfg_write(CFG_H02_10, {c[3], c[2]});
    cfg_write(CFG_H11_12, {c[5], c[4]});
    cfg_write(CFG_H20_21, {c[7], c[6]});
    cfg_write(CFG_H22, {32'($urandom), c[8]});
  endtask

  function automatic logic [31:0] rnd_scaled(int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  function automatic corr_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d, logic l);
    corr_t it;
    it.wx = a;
    it.wy = b;
    it.cx = c;
    it.cy = d;
    it.last = l;
    return it;
  endfunction

  function automatic err_result_t res(logic [31:0] e, logic s, logic [16:0] n);
    err_result_t r;
    r.err = e;
    r.sat = s;
    r.cnt = n;
    return r;
  endfunction

  dir_row_t dir_rows [$];
  logic [31:0] hc [0:8];
  logic [2:0] nsel;
  err_result_t none;

  initial begin
    corr_t it;
    int nsets, len, sb, nb, mode;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_H00_01;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    world_x_i = '0;
    world_y_i = '0;
    cam_x_i = '0;
    cam_y_i = '0;
    last_i = 1'b0;
    none = '0;
    h_r[0] = {32'd0, H_ONE};
    h_r[1] = '0;
    h_r[2] = {32'd0, H_ONE};
    h_r[3] = '0;
    h22_r = H_ONE;
    norm_r = NORM_RST;
    acc = '0;
    pts = 0;
    ovf_seen = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: identity map, L2
    dir_rows.push_back({mk(32'd0, 32'd0, 32'h3_0000, 32'h4_0000, 1'b1), 1'b1,
                        res(32'h5_0000, 1'b0, 17'd1)});
    dir_rows.push_back({mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1),
                        1'b1, res(32'hFFFF_FFFF, 1'b1, 17'd1)});
    dir_rows.push_back({mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1),
                        1'b1, res(32'hFFFF_FFFF, 1'b1, 17'd1)});
    dir_rows.push_back({mk(32'h1_0000, 32'd0, 32'h1_0000, 32'd0, 1'b0), 1'b0, none});
    dir_rows.push_back({mk(32'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b1,
                        res(32'h1_8000, 1'b0, 17'd2)});
    dir_rows.push_back({mk(32'h0012_3456, 32'hFFF0_0001, 32'h0013_0000, 32'hFFEF_8000, 1'b0),
                        1'b0, none});
    dir_rows.push_back({mk(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1),
                        1'b0, none});
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].res);
    quiesce();

    // zero denominator
    hc = '{H_ONE, 0, 0, 0, H_ONE, 0, 0, 0, 0};
    load_h(hc);
    cfg_write(CFG_NORM, {61'd0, NORM_L1});
    cfg_valid_i <= 1'b0;
    send_item(mk(32'h1_0000, 32'h2_0000, 32'd0, 32'd0, 1'b0), 1'b0, none);
    send_item(mk(32'd0, 32'd0, 32'd0, 32'd0, 1'b1), 1'b1,
              res(32'hFFFF_FFFF, 1'b1, 17'd2));
    quiesce();

    // each norm code, identity map
    hc = '{H_ONE, 0, 0, 0, H_ONE, 0, 0, 0, H_ONE};
    load_h(hc);
    for (int n = 0; n < 8; n++) begin
      if (n == 5 || n == 6) continue;
      cfg_write(CFG_NORM, 64'(n));
      cfg_valid_i <= 1'b0;
      send_item(mk(32'd0, 32'd0, 32'h2_8000, 32'hFFFE_0000, 1'b0), 1'b0, none);
      send_item(mk(32'h10_0000, 32'h1234, 32'h10_4000, 32'h1000, 1'b1), 1'b0, none);
      quiesce();
    end

    // norm changed inside a set
    send_item(mk(32'd0, 32'd0, 32'h1_0000, 32'd0, 1'b0), 1'b0, none);
    quiesce();
    cfg_write(CFG_NORM, {61'd0, NORM_L4});
    cfg_valid_i <= 1'b0;
    send_item(mk(32'd0, 32'd0, 32'h3_0000, 32'd0, 1'b1), 1'b0, none);
    quiesce();

    // extreme coefficients
    hc = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    load_h(hc);
    cfg_write(CFG_NORM, {61'd0, NORM_MAX});
    cfg_valid_i <= 1'b0;
    send_item(mk(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1),
              1'b0, none);
    send_item(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1), 1'b0, none);
    quiesce();

    // random phases
    n_items = 0;
    while (n_items < N_RANDOM) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        logic [31:0] base;
        base = (i == 0 || i == 4 || i == 8) ? H_ONE : 32'd0;
        if (mode == 0) hc[i] = $urandom;
        else if (mode == 1) hc[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if ($urandom_range(0, 3) == 0) hc[i] = base;
        else hc[i] = base + rnd_scaled((i == 2 || i == 5) ? $urandom_range(0, 30)
                                                           : $urandom_range(0, 24));
      end
      if ($urandom_range(0, 2) != 0) load_h(hc);
      case ($urandom_range(0, 3))
        0: nsel = NORM_MAX;
        1: nsel = NORM_L4;
        default: nsel = 3'($urandom_range(0, 7));
      endcase
      cfg_write(CFG_NORM, {61'($urandom), nsel});
      cfg_valid_i <= 1'b0;
      idle_en = ($urandom_range(0, 3) != 0);
      nsets = $urandom_range(1, 8);
      for (int s = 0; s < nsets; s++) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(MAX_PTS - 4, MAX_PTS + 6)
                                           : $urandom_range(1, 6);
        sb = $urandom_range(8, 31);
        nb = $urandom_range(0, sb);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            it = mk($urandom, $urandom, $urandom, $urandom, 1'($urandom));
          end else begin
            it.wx = rnd_scaled(sb);
            it.wy = rnd_scaled(sb);
            it.cx = it.wx + rnd_scaled(nb);
            it.cy = it.wy + rnd_scaled(nb);
            it.last = (k == len - 1);
          end
          if (s == nsets - 1 && k == len - 1 && $urandom_range(0, 3) == 0) it.last = 1'b0;
          send_item(it, 1'b0, none);
        end
      end
      quiesce();
    end

    idle_en = 1'b1;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
